>>> src/srms_pkg.sv
// shared constants and types for the staggered relay mask sequencer
package srms_pkg;

    localparam int MASK_W      = 8;
    localparam int IDX_W       = 3;
    localparam int INTERVAL_W  = 16;
    localparam int TIMEOUT_W   = 20;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int NUM_RELAYS_DEF = 4;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(5000);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(5 * 60 * 1000);
    localparam logic [MASK_W-1:0]     MASK_ALL_ON  = '1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MASK = 1'b1;

    localparam logic REG_STEP_INTERVAL = 1'b0;
    localparam logic REG_WATCHDOG      = 1'b1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] step_interval;
        logic [TIMEOUT_W-1:0]  watchdog_timeout;
    } t_cfg;

endpackage

>>> src/staggered_relay_mask_sequencer.sv
// top level: input register, handshake and wiring of config and engine
// Takes one word per clock while o_stall is low, either a millisecond tick or a
// new relay mask, and returns one result word per input word via the input and
// result registers; throughput is one word per clock while i_stall is low, set
// by the single step stage between them. Results are held while i_stall is
// high and the input side stalls only when both registers are full. Register
// writes are expected only while no word is in flight.
module staggered_relay_mask_sequencer #(
    parameter int NUM_RELAYS = srms_pkg::NUM_RELAYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srms_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [srms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [srms_pkg::MASK_W-1:0]       i_new_mask,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [srms_pkg::MASK_W-1:0]       o_relay_levels,
    output logic                              o_relay_changed,
    output logic [srms_pkg::IDX_W-1:0]        o_changed_index,
    output logic                              o_failsafe_active
);
    import srms_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_func;
    logic [MASK_W-1:0] r_in_mask;
    logic              adv;
    logic              take;

    assign adv     = !o_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_func <= i_func;
            r_in_mask <= i_new_mask;
        end
    end

    srms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srms_engine #(
        .NUM_RELAYS (NUM_RELAYS)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_adv             (adv),
        .i_item_valid      (r_in_valid),
        .i_func            (r_in_func),
        .i_new_mask        (r_in_mask),
        .o_valid           (o_valid),
        .o_relay_levels    (o_relay_levels),
        .o_relay_changed   (o_relay_changed),
        .o_changed_index   (o_changed_index),
        .o_failsafe_active (o_failsafe_active)
    );

endmodule

>>> src/srms_cfg.sv
// apb register file for step interval and watchdog timeout
module srms_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srms_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [srms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output srms_pkg::t_cfg                    o_cfg
);
    import srms_pkg::*;

    logic [INTERVAL_W-1:0] r_interval, n_interval;
    logic [TIMEOUT_W-1:0]  r_timeout, n_timeout;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        n_interval = r_interval;
        n_timeout  = r_timeout;
        if (wr_en) begin
            case (paddr[2])
                REG_STEP_INTERVAL: n_interval = pwdata[INTERVAL_W-1:0];
                REG_WATCHDOG:      n_timeout  = pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STEP_INTERVAL: prdata = APB_DATA_W'(r_interval);
            REG_WATCHDOG:      prdata = APB_DATA_W'(r_timeout);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_timeout  <= TIMEOUT_RST;
        end else begin
            r_interval <= n_interval;
            r_timeout  <= n_timeout;
        end
    end

    assign o_cfg.step_interval    = r_interval;
    assign o_cfg.watchdog_timeout = r_timeout;

endmodule

>>> src/srms_engine.sv
// sequencer state, per-word step logic and result register
module srms_engine #(
    parameter int NUM_RELAYS = srms_pkg::NUM_RELAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srms_pkg::t_cfg                i_cfg,
    input  logic                          i_adv,
    input  logic                          i_item_valid,
    input  logic                          i_func,
    input  logic [srms_pkg::MASK_W-1:0]   i_new_mask,
    output logic                          o_valid,
    output logic [srms_pkg::MASK_W-1:0]   o_relay_levels,
    output logic                          o_relay_changed,
    output logic [srms_pkg::IDX_W-1:0]    o_changed_index,
    output logic                          o_failsafe_active
);
    import srms_pkg::*;

    localparam logic [IDX_W:0] LastWrap = (IDX_W+1)'(NUM_RELAYS);

    logic [MASK_W-1:0]     r_req, n_req;
    logic [MASK_W-1:0]     r_app, n_app;
    logic [TIMEOUT_W-1:0]  r_mask_age, n_mask_age;
    logic [INTERVAL_W-1:0] r_step_age, n_step_age;
    logic [IDX_W-1:0]      r_cursor, n_cursor;
    logic                  r_failsafe, n_failsafe;
    logic                  n_changed;
    logic [IDX_W-1:0]      n_index;

    logic                  r_out_valid;
    logic [MASK_W-1:0]     r_out_levels;
    logic                  r_out_changed;
    logic [IDX_W-1:0]      r_out_index;
    logic                  r_out_failsafe;

    logic                  fire;
    logic [IDX_W:0]        cursor_inc;

    assign fire = i_adv & i_item_valid;

    always_comb begin
        n_req      = r_req;
        n_app      = r_app;
        n_mask_age = r_mask_age;
        n_step_age = r_step_age;
        n_cursor   = r_cursor;
        n_failsafe = r_failsafe;
        n_changed  = 1'b0;
        n_index    = '0;
        cursor_inc = '0;
        if (i_func == FUNC_MASK) begin
            n_req      = i_new_mask;
            n_mask_age = '0;
            n_failsafe = 1'b0;
        end else begin
            if (r_mask_age != '1) n_mask_age = r_mask_age + 1'b1;
            if (r_step_age != '1) n_step_age = r_step_age + 1'b1;
            if (!r_failsafe && n_mask_age >= i_cfg.watchdog_timeout) begin
                n_failsafe = 1'b1;
                n_cursor   = '0;
                n_step_age = '0;
                n_req      = MASK_ALL_ON;
            end
            if (n_step_age >= i_cfg.step_interval) begin
                if (n_req[n_cursor] != r_app[n_cursor]) begin
                    n_app[n_cursor] = n_req[n_cursor];
                    n_changed       = 1'b1;
                    n_index         = n_cursor;
                end
                cursor_inc = {1'b0, n_cursor} + 1'b1;
                if (cursor_inc >= LastWrap) begin
                    n_cursor   = '0;
                    n_failsafe = 1'b0;
                end else begin
                    n_cursor = cursor_inc[IDX_W-1:0];
                end
                n_step_age = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= MASK_ALL_ON;
            r_app       <= MASK_ALL_ON;
            r_mask_age  <= '0;
            r_step_age  <= '0;
            r_cursor    <= '0;
            r_failsafe  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_req      <= n_req;
                r_app      <= n_app;
                r_mask_age <= n_mask_age;
                r_step_age <= n_step_age;
                r_cursor   <= n_cursor;
                r_failsafe <= n_failsafe;
            end
            if (i_adv) r_out_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_levels   <= n_app;
            r_out_changed  <= n_changed;
            r_out_index    <= n_index;
            r_out_failsafe <= n_failsafe;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_relay_levels    = r_out_levels;
    assign o_relay_changed   = r_out_changed;
    assign o_changed_index   = r_out_index;
    assign o_failsafe_active = r_out_failsafe;

endmodule

>>> src/srms_checker.sv
// port-level assertions for the sequencer and their bind
module srms_checker #(
    parameter int NUM_RELAYS = srms_pkg::NUM_RELAYS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [srms_pkg::MASK_W-1:0]   o_relay_levels,
    input logic                          o_relay_changed,
    input logic [srms_pkg::IDX_W-1:0]    o_changed_index
);
    import srms_pkg::*;

    localparam logic [MASK_W-1:0] UsedMask = MASK_W'((1 << NUM_RELAYS) - 1);
    localparam logic [IDX_W:0]    RelayCount = (IDX_W+1)'(NUM_RELAYS);

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_relay_changed |-> {1'b0, o_changed_index} < RelayCount)
        else $error("switched relay index beyond relay count");

    a_index_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_relay_changed |-> o_changed_index == '0)
        else $error("relay index set without a switch");

    a_unused_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_relay_levels | UsedMask) == MASK_ALL_ON)
        else $error("unused relay driven low");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_relay_levels))
        else $error("stalled result word changed");

endmodule

bind staggered_relay_mask_sequencer srms_checker #(
    .NUM_RELAYS (NUM_RELAYS)
) u_srms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_relay_levels  (o_relay_levels),
    .o_relay_changed (o_relay_changed),
    .o_changed_index (o_changed_index)
);
